>>> sv/stream_pattern_replace_assert.svh
// Assertion macros shared by the stream_pattern_replace modules.
// All of them sample on aclk and are held off while aresetn is low.
`ifndef STREAM_PATTERN_REPLACE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define SPR_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define SPR_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> sv/spr_pkg.sv
package spr_pkg;

    // Longest pattern the window can hold
    localparam int PATTERN_MAX = 8;
    // Longest replacement, fixed by the 64-bit register
    localparam int REPLACE_MAX = 8;
    // Bytes carried by one queue entry
    localparam int DESC_BYTES  = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int DATA_W      = 8 * DESC_BYTES;
    localparam int CNT_W       = $clog2(DESC_BYTES + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    // One burst of output: count bytes from data, lowest byte first.
    // A zero count with last set is a bare end mark.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } desc_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> sv/spr_front.sv
module spr_front
    import spr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  queue_status_t         q_status,
    output logic                  in_ready,
    output logic                  push,
    output desc_t                 push_desc
);

    `include "stream_pattern_replace_assert.svh"

    logic [63:0]                  pat_bytes_reg;
    logic [LEN_W-1:0]             pat_len_reg;
    logic [63:0]                  rep_bytes_reg;
    logic [LEN_W-1:0]             rep_len_reg;

    logic [PATTERN_MAX-1:0][7:0]  win_reg, win_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    logic [PATTERN_MAX-1:0][7:0]  win_app;
    logic [CNT_W-1:0]             cnt_app;
    logic [CNT_W-1:0]             plen, rlen, emit_n;
    logic                         match, use_repl, accept;
    logic [DATA_W-1:0]            emit_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_PATTERN_BYTES:      pat_bytes_reg <= cfg_wdata[63:0];
                REG_PATTERN_LENGTH:     pat_len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_wdata[63:0];
                REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped lengths
    always_comb begin
        if (pat_len_reg == '0)
            plen = CNT_W'(1);
        else if (pat_len_reg > LEN_W'(PATTERN_MAX))
            plen = CNT_W'(PATTERN_MAX);
        else
            plen = CNT_W'(pat_len_reg);
        if (rep_len_reg > LEN_W'(REPLACE_MAX))
            rlen = CNT_W'(REPLACE_MAX);
        else
            rlen = CNT_W'(rep_len_reg);
    end

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Append, compare and classify the new byte
    always_comb begin
        win_app  = win_reg;
        cnt_app  = cnt_reg;
        if (cnt_reg < CNT_W'(PATTERN_MAX)) begin
            win_app[cnt_reg[IDX_W-1:0]] = in_byte;
            cnt_app = cnt_reg + CNT_W'(1);
        end

        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((CNT_W'(i) < plen) && (win_app[i] != pat_bytes_reg[8*i +: 8]))
                match = 1'b0;
        end

        use_repl = 1'b0;
        emit_n   = '0;
        if (cnt_app > plen) begin
            // pattern shortened: drain down to one short of the pattern
            emit_n = cnt_app - (plen - CNT_W'(1));
        end else if (cnt_app == plen) begin
            if (match) begin
                use_repl = 1'b1;
                emit_n   = rlen;
            end else begin
                emit_n   = CNT_W'(1);
            end
        end
        // final byte flushes the whole window
        if (in_last && !use_repl)
            emit_n = cnt_app;

        if (emit_n == '0)
            emit_data = '0;
        else if (use_repl)
            emit_data = DATA_W'(rep_bytes_reg);
        else
            emit_data = DATA_W'(win_app);

        win_next = win_app >> {emit_n, 3'b000};
        if (in_last || use_repl)
            cnt_next = '0;
        else
            cnt_next = cnt_app - emit_n;
    end

    assign push            = accept && ((emit_n != '0) || in_last);
    assign push_desc.data  = emit_data;
    assign push_desc.count = emit_n;
    assign push_desc.last  = in_last;

    // Window state
    always_ff @(posedge aclk) begin
        if (!aresetn)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (accept)
            win_reg <= win_next;
    end

    // Window never stays full between words
    `SPR_ASSERT_NOW(a_win_room, 1'b1, cnt_reg < CNT_W'(PATTERN_MAX), "window left full")

    // A final byte always leaves the window empty
    `SPR_ASSERT_NEXT(a_last_flush, accept && in_last, cnt_reg == '0, "window kept after last")

endmodule

>>> sv/spr_queue.sv
module spr_queue
    import spr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  desc_t         push_desc,
    input  logic          pop,
    output desc_t         pop_desc,
    output queue_status_t status
);

    `include "stream_pattern_replace_assert.svh"

    desc_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_desc     = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    `SPR_ASSERT_NOW(a_no_overflow, push, !status.full, "push into full queue")
    `SPR_ASSERT_NOW(a_no_underflow, pop, !status.empty, "pop from empty queue")
    `SPR_ASSERT_NOW(a_level, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue level out of range")

endmodule

>>> sv/spr_back.sv
module spr_back
    import spr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  desc_t         pop_desc,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_byte_valid,
    output logic          out_last
);

    `include "stream_pattern_replace_assert.svh"

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              last_reg, last_next;
    logic              final_beat, load;

    // Current burst drives the output word directly
    assign final_beat     = (rem_reg <= CNT_W'(1));
    assign out_valid      = valid_reg;
    assign out_byte       = data_reg[7:0];
    assign out_byte_valid = (rem_reg != '0);
    assign out_last       = last_reg && final_beat;

    // Take the next burst when idle or when the last word of this one leaves
    assign load = (!valid_reg || (out_ready && final_beat)) && !q_status.empty;
    assign pop  = load;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = pop_desc.data;
            rem_next   = pop_desc.count;
            last_next  = pop_desc.last;
        end else if (valid_reg && out_ready) begin
            if (final_beat) begin
                valid_next = 1'b0;
            end else begin
                data_next = data_reg >> 8;
                rem_next  = rem_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rem_reg  <= rem_next;
        last_reg <= last_next;
    end

    // A word without a byte is only ever the end mark
    `SPR_ASSERT_NOW(a_bare_is_end, valid_reg && !out_byte_valid, out_last, "bare word without end")

    // A burst never holds more bytes than a queue entry
    `SPR_ASSERT_NOW(a_rem_range, valid_reg, rem_reg <= CNT_W'(DESC_BYTES), "burst length out of range")

endmodule

>>> sv/stream_pattern_replace.sv
// Channel   Dir  Payload (low bit first)                  Handshake
// s_        in   tdata[7:0] text_byte, tlast text_last    s_tvalid / s_tready
// m_        out  tdata[7:0] out_byte, tuser byte_valid,   m_tvalid / m_tready
//                tlast out_last
// cfg_      in   cfg_index selects register, cfg_wdata    cfg_we, no wait
//
// One text byte is taken per cycle while the four-entry burst queue has room.
// The back end sends one word per cycle while m_tready is high; a replacement of
// r bytes goes out as r words, so s_tready drops when replacements outrun the input.
// A word passes through a queue slot and then the output stage registers to reach m_.
// aresetn is synchronous: window, queue and output stage are emptied and the
// registers return to pattern 0, length 1, empty replacement.
// m_tready low holds the current word and fills the queue behind it.
module stream_pattern_replace
    import spr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tuser,   // [0] byte_valid
    output logic                  m_tlast
);

    queue_status_t q_status;
    desc_t         push_desc, pop_desc;
    logic          push, pop;

    spr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_status  (q_status),
        .in_ready  (s_tready),
        .push      (push),
        .push_desc (push_desc)
    );

    spr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .status    (q_status)
    );

    spr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_status       (q_status),
        .pop_desc       (pop_desc),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_byte_valid (m_tuser),
        .out_last       (m_tlast)
    );

endmodule
